// ===== rtl/core/rsc_pkg.sv =====
// Shared constants, types and functions of the radix string converter.
`timescale 1ns / 1ps

package rsc_pkg;

   localparam int VALUE_BITS_DEF = 31;
   localparam int MAX_DIGITS_DEF = 32;

   localparam int CHAR_W  = 8;
   localparam int RADIX_W = 2;
   localparam int DIGIT_W = 4;
   localparam int CSR_W   = 2;

   localparam logic [RADIX_W-1:0] RADIX_BIN = 2'd0;
   localparam logic [RADIX_W-1:0] RADIX_B5  = 2'd1;
   localparam logic [RADIX_W-1:0] RADIX_OCT = 2'd2;
   localparam logic [RADIX_W-1:0] RADIX_HEX = 2'd3;

   localparam logic [CSR_W-1:0] CSR_IN_RADIX  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_OUT_RADIX = 2'd1;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UP_F = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LO_F = 8'h66;

   typedef struct packed {
      logic start;
      logic err;
   } acc_ctl_type;

   function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] dv);
      logic [CHAR_W-1:0] ch;
      if (dv < 4'd10) begin
         ch = CHAR_ZERO + {4'd0, dv};
      end else begin
         ch = CHAR_UP_A + {4'd0, dv} - 8'd10;
      end
      return ch;
   endfunction

endpackage

// ===== rtl/core/radix_string_converter.sv =====
// Top level of the radix string converter: stream ports, register file and block wiring.
`timescale 1ns / 1ps

// Takes one number as ASCII characters, most significant first, in the input
// radix held by register 0 (0 binary, 1 base 5, 2 octal, 3 hex), and after the
// character marked by req_tlast sends the value as ASCII digits in the output
// radix held by register 1, most significant digit first, upper-case hex, with
// rsp_tlast on the final digit. An invalid digit (binary input reads any
// character but 1 as 0), a value above 2^VALUE_BITS - 1 or more than
// MAX_DIGITS digits gives one item with rsp_tdata 0 and rsp_tuser set instead.
// Characters before the last are accepted back to back. After the last one the
// serial converter runs: binary, octal and hex output peel one digit per cycle,
// base 5 output runs a bit-serial divide per digit; each digit then passes the
// digit memory read, the output register load and SEND, waiting on rsp_tready.
// No character is taken from the last one until the final result transfer.
module radix_string_converter #(
   parameter int VALUE_BITS = rsc_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = rsc_pkg::MAX_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rsc_pkg::CHAR_W-1:0]       req_tdata,   // char_in
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rsc_pkg::CHAR_W-1:0]       rsp_tdata,   // digit_char
   output logic                             rsp_tlast,
   output logic                             rsp_tuser,   // bad_input
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rsc_pkg::CSR_W-1:0]        csr_index,
   input  logic [rsc_pkg::RADIX_W-1:0]      csr_wdata
);

   logic [rsc_pkg::RADIX_W-1:0] in_radix_ff, in_radix_in;
   logic [rsc_pkg::RADIX_W-1:0] out_radix_ff, out_radix_in;

   logic                        req_accept;
   logic                        conv_busy;
   logic [VALUE_BITS-1:0]       acc_value;
   rsc_pkg::acc_ctl_type        acc_ctl;

   assign csr_ready  = 1'b1;
   assign req_tready = !acc_ctl.start && !conv_busy;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_radix_in  = in_radix_ff;
      out_radix_in = out_radix_ff;
      if (csr_valid) begin
         case (csr_index)
            rsc_pkg::CSR_IN_RADIX:  in_radix_in  = csr_wdata;
            rsc_pkg::CSR_OUT_RADIX: out_radix_in = csr_wdata;
            default: begin
               in_radix_in = in_radix_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_radix_ff  <= rsc_pkg::RADIX_HEX;
         out_radix_ff <= rsc_pkg::RADIX_BIN;
      end else begin
         in_radix_ff  <= in_radix_in;
         out_radix_ff <= out_radix_in;
      end
   end

   rsc_accum #(
      .VALUE_BITS (VALUE_BITS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .char_in   (req_tdata),
      .last_char (req_tlast),
      .in_radix  (in_radix_ff),
      .value     (acc_value),
      .ctl       (acc_ctl)
   );

   rsc_convert #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_convert (
      .clock      (clock),
      .reset      (reset),
      .ctl        (acc_ctl),
      .value      (acc_value),
      .out_radix  (out_radix_ff),
      .busy       (conv_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/core/rsc_accum.sv =====
// Character decoder and value accumulator with overflow detection.
`timescale 1ns / 1ps

module rsc_accum #(
   parameter int VALUE_BITS = rsc_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [rsc_pkg::CHAR_W-1:0]       char_in,
   input  logic                             last_char,
   input  logic [rsc_pkg::RADIX_W-1:0]      in_radix,
   output logic [VALUE_BITS-1:0]            value,
   output rsc_pkg::acc_ctl_type             ctl
);

   localparam int PW = VALUE_BITS + 4;

   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  err_ff, err_in;
   logic                  start_ff, start_in;

   logic                        is_num, is_up, is_lo, dig_ok;
   logic [rsc_pkg::DIGIT_W-1:0] dig;
   logic [PW-1:0]               acc_ext, prod;

   always_comb begin
      is_num = (char_in >= rsc_pkg::CHAR_ZERO) && (char_in <= rsc_pkg::CHAR_NINE);
      is_up  = (char_in >= rsc_pkg::CHAR_UP_A) && (char_in <= rsc_pkg::CHAR_UP_F);
      is_lo  = (char_in >= rsc_pkg::CHAR_LO_A) && (char_in <= rsc_pkg::CHAR_LO_F);
      acc_ext = {4'd0, acc_ff};
      dig    = char_in[3:0];
      dig_ok = 1'b0;
      prod   = acc_ext;
      case (in_radix)
         rsc_pkg::RADIX_BIN: begin
            dig    = (char_in == rsc_pkg::CHAR_ONE) ? 4'd1 : 4'd0;
            dig_ok = 1'b1;
            prod   = (acc_ext << 1) + {{(PW-4){1'b0}}, dig};
         end
         rsc_pkg::RADIX_B5: begin
            dig_ok = is_num && (char_in[3:0] < 4'd5);
            prod   = (acc_ext << 2) + acc_ext + {{(PW-4){1'b0}}, dig};
         end
         rsc_pkg::RADIX_OCT: begin
            dig_ok = is_num && (char_in[3:0] < 4'd8);
            prod   = (acc_ext << 3) + {{(PW-4){1'b0}}, dig};
         end
         rsc_pkg::RADIX_HEX: begin
            dig    = is_num ? char_in[3:0] : char_in[3:0] + 4'd9;
            dig_ok = is_num || is_up || is_lo;
            prod   = (acc_ext << 4) + {{(PW-4){1'b0}}, dig};
         end
         default: begin
            dig_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      acc_in   = acc_ff;
      err_in   = err_ff;
      start_in = 1'b0;
      if (start_ff) begin
         acc_in = '0;
         err_in = 1'b0;
      end else if (accept) begin
         start_in = last_char;
         if (!dig_ok || (|prod[PW-1:VALUE_BITS])) begin
            err_in = 1'b1;
         end else begin
            acc_in = prod[VALUE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         err_ff   <= 1'b0;
         start_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         err_ff   <= err_in;
         start_ff <= start_in;
      end
   end

   assign value     = acc_ff;
   assign ctl.start = start_ff;
   assign ctl.err   = err_ff;

endmodule

// ===== rtl/core/rsc_convert.sv =====
// Serial radix converter: digit extraction, digit memory and result output register.
`timescale 1ns / 1ps

module rsc_convert #(
   parameter int VALUE_BITS = rsc_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = rsc_pkg::MAX_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rsc_pkg::acc_ctl_type             ctl,
   input  logic [VALUE_BITS-1:0]            value,
   input  logic [rsc_pkg::RADIX_W-1:0]      out_radix,
   output logic                             busy,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rsc_pkg::CHAR_W-1:0]       rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tuser
);

   localparam int BW = $clog2(VALUE_BITS);
   localparam int NW = $clog2(MAX_DIGITS + 1);
   localparam int AW = $clog2(MAX_DIGITS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_POW2  = 3'd1;
   localparam logic [2:0] S_DIV5  = 3'd2;
   localparam logic [2:0] S_FETCH = 3'd3;
   localparam logic [2:0] S_LOAD  = 3'd4;
   localparam logic [2:0] S_SEND  = 3'd5;

   logic [2:0]                  state_ff, state_in;
   logic [VALUE_BITS-1:0]       val_ff, val_in;
   logic [2:0]                  rem_ff, rem_in;
   logic [BW-1:0]               bcnt_ff, bcnt_in;
   logic [NW-1:0]               cnt_ff, cnt_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic                        valid_ff, valid_in;
   logic [rsc_pkg::CHAR_W-1:0]  data_ff, data_in;
   logic                        last_ff, last_in;
   logic                        bad_ff, bad_in;

   logic [rsc_pkg::DIGIT_W-1:0] digit_store_ff [MAX_DIGITS];
   logic [rsc_pkg::DIGIT_W-1:0] rd_data_ff;

   logic [rsc_pkg::DIGIT_W-1:0] dig;
   logic [VALUE_BITS-1:0]       val_next;
   logic                        dig_done;
   logic [3:0]                  trial;
   logic                        ge5;
   logic [2:0]                  rem_next;
   logic [NW-1:0]               cnt_next;

   always_comb begin
      trial    = {rem_ff, val_ff[VALUE_BITS-1]};
      ge5      = (trial >= 4'd5);
      rem_next = ge5 ? 3'(trial - 4'd5) : trial[2:0];
      cnt_next = cnt_ff + 1'b1;
      dig      = '0;
      val_next = val_ff;
      dig_done = 1'b0;
      if (state_ff == S_POW2) begin
         dig_done = 1'b1;
         case (out_radix)
            rsc_pkg::RADIX_BIN: begin
               dig      = {3'd0, val_ff[0]};
               val_next = val_ff >> 1;
            end
            rsc_pkg::RADIX_OCT: begin
               dig      = {1'b0, val_ff[2:0]};
               val_next = val_ff >> 3;
            end
            default: begin
               dig      = val_ff[3:0];
               val_next = val_ff >> 4;
            end
         endcase
      end else if (state_ff == S_DIV5) begin
         val_next = {val_ff[VALUE_BITS-2:0], ge5};
         dig      = {1'b0, rem_next};
         dig_done = (bcnt_ff == BW'(VALUE_BITS - 1));
      end
   end

   always_comb begin
      state_in = state_ff;
      val_in   = val_ff;
      rem_in   = rem_ff;
      bcnt_in  = bcnt_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      bad_in   = bad_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               if (ctl.err) begin
                  data_in  = '0;
                  last_in  = 1'b1;
                  bad_in   = 1'b1;
                  valid_in = 1'b1;
                  state_in = S_SEND;
               end else begin
                  val_in   = value;
                  rem_in   = '0;
                  bcnt_in  = '0;
                  cnt_in   = '0;
                  state_in = (out_radix == rsc_pkg::RADIX_B5) ? S_DIV5 : S_POW2;
               end
            end
         end
         S_POW2, S_DIV5: begin
            val_in  = val_next;
            rem_in  = rem_next;
            bcnt_in = bcnt_ff + 1'b1;
            if (dig_done) begin
               cnt_in  = cnt_next;
               rem_in  = '0;
               bcnt_in = '0;
               if (val_next == '0) begin
                  idx_in   = cnt_ff[AW-1:0];
                  state_in = S_FETCH;
               end else if (cnt_next == NW'(MAX_DIGITS)) begin
                  data_in  = '0;
                  last_in  = 1'b1;
                  bad_in   = 1'b1;
                  valid_in = 1'b1;
                  state_in = S_SEND;
               end
            end
         end
         S_FETCH: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            data_in  = rsc_pkg::digit_ascii(rd_data_ff);
            last_in  = (idx_ff == '0);
            bad_in   = 1'b0;
            valid_in = 1'b1;
            state_in = S_SEND;
         end
         S_SEND: begin
            if (rsp_tready) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         bcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         bcnt_ff  <= bcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      idx_ff  <= idx_in;
      data_ff <= data_in;
      last_ff <= last_in;
      bad_ff  <= bad_in;
   end

   always_ff @(posedge clock) begin
      if (dig_done) begin
         digit_store_ff[cnt_ff[AW-1:0]] <= dig;
      end
      rd_data_ff <= digit_store_ff[idx_ff];
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = bad_ff;

endmodule

// ===== tb/radix_string_converter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the radix string converter: directed table, then random numbers.
module radix_string_converter_tb;
   import rsc_pkg::*;

   localparam int HALF_PERIOD    = 2;
   localparam int RESET_CYCLES   = 5;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 44;
   localparam longint unsigned VALUE_CAP = (64'd1 << VALUE_BITS_DEF) - 64'd1;

   localparam int SEND_IDLE_PCT [4] = '{0, 86, 0, 24};
   localparam int RECV_STALL_PCT [4] = '{0, 0, 86, 24};

   typedef struct packed {
      logic [CHAR_W-1:0] digit;
      logic              run_end;
      logic              bad;
   } digit_item_t;

   typedef enum logic [1:0] {SET_IN, SET_OUT, FEED, FEED_KNOWN} plan_kind_t;

   typedef struct packed {
      plan_kind_t         kind;
      logic [RADIX_W-1:0] radix;
      logic [CHAR_W-1:0]  ch;
      logic               last;
      logic [CHAR_W-1:0]  want;
   } plan_row_t;

   // FEED_KNOWN rows carry the single result: want 0 marks the error transfer.
   localparam plan_row_t DIRECTED_PLAN [35] = '{
      '{FEED_KNOWN, RADIX_HEX, "0",   1'b1, "0"},
      '{SET_OUT,    RADIX_OCT, 8'h00, 1'b0, 8'h00},
      '{FEED_KNOWN, RADIX_HEX, 8'h00, 1'b1, 8'h00},
      '{FEED_KNOWN, RADIX_HEX, 8'hFF, 1'b1, 8'h00},
      '{FEED,       RADIX_HEX, "7",   1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "F",   1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "F",   1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "F",   1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "F",   1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "F",   1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "F",   1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "f",   1'b1, 8'h00},
      '{SET_OUT,    RADIX_HEX, 8'h00, 1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "F",   1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "F",   1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "F",   1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "F",   1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "F",   1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "F",   1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "F",   1'b0, 8'h00},
      '{FEED_KNOWN, RADIX_HEX, "F",   1'b1, 8'h00},
      '{SET_IN,     RADIX_B5,  8'h00, 1'b0, 8'h00},
      '{SET_OUT,    RADIX_B5,  8'h00, 1'b0, 8'h00},
      '{FEED_KNOWN, RADIX_B5,  "5",   1'b1, 8'h00},
      '{FEED,       RADIX_B5,  "1",   1'b0, 8'h00},
      '{FEED,       RADIX_B5,  "0",   1'b1, 8'h00},
      '{SET_IN,     RADIX_BIN, 8'h00, 1'b0, 8'h00},
      '{FEED,       RADIX_BIN, "1",   1'b0, 8'h00},
      '{FEED,       RADIX_BIN, "x",   1'b1, 8'h00},
      '{SET_IN,     RADIX_OCT, 8'h00, 1'b0, 8'h00},
      '{FEED_KNOWN, RADIX_OCT, "8",   1'b1, 8'h00},
      '{SET_IN,     RADIX_B5,  8'h00, 1'b0, 8'h00},
      '{FEED,       RADIX_B5,  "3",   1'b0, 8'h00},
      '{SET_IN,     RADIX_HEX, 8'h00, 1'b0, 8'h00},
      '{FEED,       RADIX_HEX, "C",   1'b1, 8'h00}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [CHAR_W-1:0]  req_tdata = '0;
   logic               req_tlast = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [CHAR_W-1:0]  rsp_tdata;
   logic               rsp_tlast;
   logic               rsp_tuser;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_W-1:0]   csr_index = '0;
   logic [RADIX_W-1:0] csr_wdata = '0;

   logic [RADIX_W-1:0] in_radix_now = RADIX_HEX;
   logic [RADIX_W-1:0] out_radix_now = RADIX_BIN;
   longint unsigned    value_acc = 0;
   bit                 value_bad = 1'b0;
   digit_item_t        fresh_digits [$];
   digit_item_t        pending_digits [$];
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;
   int                 mismatches = 0;
   int                 quiet_cycles = 0;

   radix_string_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic longint unsigned radix_base(input logic [RADIX_W-1:0] code);
      longint unsigned base;
      case (code)
         RADIX_BIN: base = 2;
         RADIX_B5:  base = 5;
         RADIX_OCT: base = 8;
         default:   base = 16;
      endcase
      return base;
   endfunction

   task automatic report_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
      $display("mismatch %s: want %0h got %0h at %0t", field, want, got, $time);
      mismatches++;
   endtask

   // Fold one character into the running value; on the last one, queue its digits.
   task automatic accumulate(input logic [CHAR_W-1:0] ch, input logic last);
      int                 d;
      int                 n;
      longint unsigned    base;
      longint unsigned    v;
      logic [DIGIT_W-1:0] digs [MAX_DIGITS_DEF];
      digit_item_t        item;
      d = -1;
      base = radix_base(in_radix_now);
      if (in_radix_now == RADIX_BIN) begin
         d = (ch == CHAR_ONE) ? 1 : 0;
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         d = int'(ch) - int'(CHAR_ZERO);
      end else if (in_radix_now == RADIX_HEX && ch >= CHAR_UP_A && ch <= CHAR_UP_F) begin
         d = int'(ch) - int'(CHAR_UP_A) + 10;
      end else if (in_radix_now == RADIX_HEX && ch >= CHAR_LO_A && ch <= CHAR_LO_F) begin
         d = int'(ch) - int'(CHAR_LO_A) + 10;
      end
      if (d >= int'(base)) d = -1;
      if (d < 0) begin
         value_bad = 1'b1;
      end else if (value_acc > (VALUE_CAP - longint'(d)) / base) begin
         value_bad = 1'b1;
      end else begin
         value_acc = value_acc * base + longint'(d);
      end
      if (!last) return;
      n = 0;
      if (!value_bad) begin
         v = value_acc;
         base = radix_base(out_radix_now);
         do begin
            digs[n] = DIGIT_W'(v % base);
            v = v / base;
            n++;
         end while (v != 0 && n < MAX_DIGITS_DEF);
         if (v != 0) value_bad = 1'b1;
      end
      if (value_bad) begin
         fresh_digits.push_back('{8'h00, 1'b1, 1'b1});
      end else begin
         for (int k = n - 1; k >= 0; k--) begin
            item.digit = (digs[k] < 10) ? CHAR_ZERO + CHAR_W'(digs[k])
                                        : CHAR_UP_A + CHAR_W'(digs[k]) - 8'd10;
            item.run_end = (k == 0);
            item.bad = 1'b0;
            fresh_digits.push_back(item);
         end
      end
      value_acc = 0;
      value_bad = 1'b0;
   endtask

   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last, input bit known,
                            input logic [CHAR_W-1:0] want);
      req_tdata <= ch;
      req_tlast <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fresh_digits.delete();
      accumulate(ch, last);
      if (known) begin
         pending_digits.push_back('{want, 1'b1, want == 8'h00});
      end else begin
         foreach (fresh_digits[i]) pending_digits.push_back(fresh_digits[i]);
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [CSR_W-1:0] index, input logic [RADIX_W-1:0] code);
      csr_index <= index;
      csr_wdata <= code;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == CSR_IN_RADIX) in_radix_now = code;
      else out_radix_now = code;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off until every pending digit has drained and the converter is quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      digit_item_t want_item;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_digits.size() == 0) begin
               report_mismatch("unexpected transfer", 0, rsp_tdata);
            end else begin
               want_item = pending_digits.pop_front();
               if (rsp_tdata !== want_item.digit)
                  report_mismatch("digit_char", want_item.digit, rsp_tdata);
               if (rsp_tlast !== want_item.run_end)
                  report_mismatch("end_of_run", want_item.run_end, rsp_tlast);
               if (rsp_tuser !== want_item.bad)
                  report_mismatch("bad_input", want_item.bad, rsp_tuser);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned        length;
      int unsigned        full_len;
      int unsigned        d;
      int                 phase_sent;
      logic [CHAR_W-1:0]  ch;
      logic [RADIX_W-1:0] in_code;
      logic [RADIX_W-1:0] out_code;
      plan_row_t          row;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < $size(DIRECTED_PLAN); i++) begin
         row = DIRECTED_PLAN[i];
         case (row.kind)
            SET_IN: begin
               settle();
               write_csr(CSR_IN_RADIX, row.radix);
            end
            SET_OUT: begin
               settle();
               write_csr(CSR_OUT_RADIX, row.radix);
            end
            FEED:    send_char(row.ch, row.last, 1'b0, row.want);
            default: send_char(row.ch, row.last, 1'b1, row.want);
         endcase
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         case (p)
            0: begin in_code = RADIX_BIN; out_code = RADIX_HEX; end
            1: begin in_code = RADIX_HEX; out_code = RADIX_BIN; end
            2: begin in_code = RADIX_B5;  out_code = RADIX_OCT; end
            3: begin in_code = RADIX_OCT; out_code = RADIX_B5;  end
            default: begin
               in_code = RADIX_W'($urandom_range(3));
               out_code = RADIX_W'($urandom_range(3));
            end
         endcase
         write_csr(CSR_IN_RADIX, in_code);
         write_csr(CSR_OUT_RADIX, out_code);
         send_idle_pct = SEND_IDLE_PCT[p % 4];
         recv_stall_pct = RECV_STALL_PCT[p % 4];
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS) begin
            if ($urandom_range(99) < 75) begin
               case (in_code)
                  RADIX_BIN: full_len = 31;
                  RADIX_B5:  full_len = 14;
                  RADIX_OCT: full_len = 11;
                  default:   full_len = 8;
               endcase
               // mostly short numbers; the rest straddle the overflow boundary
               if ($urandom_range(99) < 60) length = $urandom_range(4, 1);
               else length = $urandom_range(full_len + 1, full_len - 1);
               for (int k = 0; k < length; k++) begin
                  d = $urandom_range(int'(radix_base(in_code)) - 1);
                  if (d < 10) ch = CHAR_ZERO + CHAR_W'(d);
                  else if ($urandom_range(1) == 1) ch = CHAR_UP_A + CHAR_W'(d - 10);
                  else ch = CHAR_LO_A + CHAR_W'(d - 10);
                  send_char(ch, k == length - 1, 1'b0, 8'h00);
               end
            end else begin
               length = $urandom_range(3, 1);
               for (int k = 0; k < length; k++) begin
                  send_char(CHAR_W'($urandom_range(255)), k == length - 1, 1'b0, 8'h00);
               end
            end
            phase_sent += length;
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rsc_pkg.sv
rtl/core/rsc_accum.sv
rtl/core/rsc_convert.sv
rtl/core/radix_string_converter.sv
tb/radix_string_converter_tb.sv
